### hdl/pmp_rac_pkg.sv
// Package: item types, codes and sizes for the protection region check.
`timescale 1ns / 1ps

package pmp_rac_pkg;

  localparam int NUM_ENTRIES = 64;
  localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int GROUP_SIZE  = 8;
  localparam int NUM_GROUPS  = (NUM_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PAD_ENTRIES = NUM_GROUPS * GROUP_SIZE;

  localparam logic [1:0] ACT_CHECK = 2'd0;
  localparam logic [1:0] ACT_SET   = 2'd1;
  localparam logic [1:0] ACT_WORD  = 2'd2;

  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_TOR   = 2'd1;
  localparam logic [1:0] MODE_NA4   = 2'd2;
  localparam logic [1:0] MODE_NAPOT = 2'd3;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_EXEC  = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  entry_index;
    logic [31:0] write_data;
    logic [33:0] phys_address;
    logic [1:0]  access_kind;
  } req_t;

  typedef struct packed {
    logic       granted;
    logic       region_hit;
    logic [5:0] hit_index;
  } res_t;

  typedef struct packed {
    logic                   valid;
    logic [PAD_ENTRIES-1:0] hit;
    logic [PAD_ENTRIES-1:0] perm;
  } match_stage_t;

endpackage

### hdl/pmp_rac_table.sv
// Entry table with one match lane per entry and the registered match vector.
`timescale 1ns / 1ps

module pmp_rac_table (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  input  pmp_rac_pkg::req_t         item,
  output pmp_rac_pkg::match_stage_t match_q
);
  import pmp_rac_pkg::*;

  logic [7:0]  settings [NUM_ENTRIES];
  logic [31:0] words    [NUM_ENTRIES];

  logic                   wr_en;
  logic                   chk;
  logic [PAD_ENTRIES-1:0] hit_next;
  logic [PAD_ENTRIES-1:0] perm_next;

  assign wr_en = item_valid && (item.action == ACT_SET || item.action == ACT_WORD) &&
                 ({1'b0, item.entry_index} < 7'(NUM_ENTRIES));
  assign chk   = item_valid && item.action == ACT_CHECK;

  always_ff @(posedge clk) begin
    if (rst) begin
      settings <= '{default: '0};
      words    <= '{default: '0};
    end else if (wr_en) begin
      if (item.action == ACT_SET) begin
        settings[item.entry_index[IDX_W-1:0]] <= item.write_data[7:0];
      end else begin
        words[item.entry_index[IDX_W-1:0]] <= item.write_data;
      end
    end
  end

  always_comb begin
    logic [33:0] lo;
    logic [33:0] hi;
    logic [32:0] wp1;
    logic [31:0] care;
    logic        m;
    logic        p;
    hit_next  = '0;
    perm_next = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      lo   = (i == 0) ? 34'd0 : {words[(i == 0) ? 0 : i - 1], 2'b00};
      hi   = {words[i], 2'b00};
      wp1  = {1'b0, words[i]} + 33'd1;
      care = ~(words[i] ^ wp1[31:0]);
      case (settings[i][4:3])
        MODE_TOR:   m = (item.phys_address >= lo) && (item.phys_address < hi);
        MODE_NA4:   m = (item.phys_address[33:2] == words[i]);
        MODE_NAPOT: m = ((item.phys_address[33:2] ^ words[i]) & care) == 32'd0;
        default:    m = 1'b0;
      endcase
      case (item.access_kind)
        KIND_READ:  p = settings[i][0];
        KIND_WRITE: p = settings[i][1];
        KIND_EXEC:  p = settings[i][2];
        default:    p = 1'b0;
      endcase
      hit_next[i]  = m;
      perm_next[i] = p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_q.valid <= 1'b0;
    end else begin
      match_q.valid <= chk;
    end
    match_q.hit  <= hit_next;
    match_q.perm <= perm_next;
  end

endmodule

### hdl/pmp_rac_prio.sv
// Two-stage lowest-index priority pick over the match vector.
`timescale 1ns / 1ps

module pmp_rac_prio (
  input  logic                      clk,
  input  logic                      rst,
  input  pmp_rac_pkg::match_stage_t match_q,
  output logic                      done,
  output pmp_rac_pkg::res_t         result
);
  import pmp_rac_pkg::*;

  logic       a_valid;
  logic       grp_hit  [NUM_GROUPS];
  logic [2:0] grp_idx  [NUM_GROUPS];
  logic       grp_perm [NUM_GROUPS];

  logic       grp_hit_next  [NUM_GROUPS];
  logic [2:0] grp_idx_next  [NUM_GROUPS];
  logic       grp_perm_next [NUM_GROUPS];
  res_t       result_next;

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_hit_next[g]  = 1'b0;
      grp_idx_next[g]  = 3'd0;
      grp_perm_next[g] = 1'b0;
      for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
        if (match_q.hit[g*GROUP_SIZE + j]) begin
          grp_hit_next[g]  = 1'b1;
          grp_idx_next[g]  = 3'(j);
          grp_perm_next[g] = match_q.perm[g*GROUP_SIZE + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= match_q.valid;
    end
    grp_hit  <= grp_hit_next;
    grp_idx  <= grp_idx_next;
    grp_perm <= grp_perm_next;
  end

  always_comb begin
    result_next = '0;
    for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
      if (grp_hit[g]) begin
        result_next.granted    = grp_perm[g];
        result_next.region_hit = 1'b1;
        result_next.hit_index  = 6'(g * GROUP_SIZE) + {3'b000, grp_idx[g]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= a_valid;
    end
    result <= result_next;
  end

`ifndef SYNTH
  a_done_follows_group: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(a_valid))
    else $error("result strobe without a group stage item");

  a_group_follows_match: assert property (@(posedge clk) disable iff (rst)
    a_valid |-> $past(match_q.valid))
    else $error("group stage item without a match stage item");

  a_miss_is_clean: assert property (@(posedge clk) disable iff (rst)
    (done && !result.region_hit) |-> (!result.granted && result.hit_index == 6'd0))
    else $error("miss result carries grant or index");
`endif

endmodule

### hdl/pmp_rac_top_dummy_never_used.sv
// Input register: takes each accepted item into the pipeline.
`timescale 1ns / 1ps

module pmp_rac_hold (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  pmp_rac_pkg::req_t request,
  output logic              item_valid,
  output pmp_rac_pkg::req_t item
);
  import pmp_rac_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= start && !busy;
    end
    item <= request;
  end

endmodule

### hdl/pmp_region_access_check.sv
// Top level: protection region access check, four-stage pipeline.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------
//  request  | start, busy          | request (req_t)
//  result   | done (one-cycle)     | result  (res_t)
//
// One item per cycle while busy is low; a check gives its result after passing
// the input register, per-entry match lanes, group pick and final pick.
// Write items update the table from the input register and give no result.
// Synchronous reset clears the table; busy is a registered copy of rst, so it
// rises after reset is applied and falls only after reset is released.
// The receiver cannot stall, so the pipeline never stops.
`timescale 1ns / 1ps

module pmp_region_access_check (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pmp_rac_pkg::req_t request,
  output logic              done,
  output pmp_rac_pkg::res_t result
);
  import pmp_rac_pkg::*;

  logic         item_valid;
  req_t         item;
  match_stage_t match_q;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  pmp_rac_hold u_hold (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .item_valid (item_valid),
    .item       (item)
  );

  pmp_rac_table u_table (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .match_q    (match_q)
  );

  pmp_rac_prio u_prio (
    .clk     (clk),
    .rst     (rst),
    .match_q (match_q),
    .done    (done),
    .result  (result)
  );

`ifndef SYNTH
  a_done_from_check: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && request.action == ACT_CHECK, 4))
    else $error("result without a check item four cycles earlier");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.action != ACT_CHECK) |-> ##4 !done)
    else $error("result produced by a non-check item");

  a_busy_in_reset: assert property (@(posedge clk)
    rst |=> busy)
    else $error("busy low right after a reset cycle");
`endif

endmodule

### test/pmp_region_access_check_tb.sv
// Testbench for pmp_region_access_check: directed and random items, checked by a behavioral model.
`timescale 1ns / 1ps

module pmp_region_access_check_tb;
  import pmp_rac_pkg::*;

  localparam int         ITEM_TARGET  = 1450;
  localparam int         LIMIT_CYCLES = 200000;
  localparam int         SETTLE       = 10;
  localparam logic [1:0] ACT_UNUSED   = 2'd3;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam logic [2:0] PERM_R       = 3'b001;
  localparam logic [2:0] PERM_W       = 3'b010;
  localparam logic [2:0] PERM_X       = 3'b100;

  typedef struct {
    req_t req;
    int   gap_pct;
    bit   drain;
  } access_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t request = '0;
  logic busy;
  logic done;
  res_t result;

  access_item_t access_items[$];
  res_t         pending_verdicts[$];
  res_t         verdict;
  int           errors = 0;
  int           cycles = 0;

  // model tables, updated in acceptance order
  logic [7:0]  prot_setting[NUM_ENTRIES];
  logic [31:0] prot_word[NUM_ENTRIES];
  // tables as the stimulus plan sees them, for aiming addresses
  logic [1:0]  plan_mode[NUM_ENTRIES];
  logic [31:0] plan_word[NUM_ENTRIES];
  int          cur_gap = 0;
  bit          drain_next = 1'b0;
  int          n_items = 0;

  pmp_region_access_check u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always #5 clk = ~clk;

  function automatic void region_bounds(input int idx, input logic [1:0] mode,
                                        input logic [31:0] word, input logic [31:0] prev,
                                        output logic [35:0] lo, output logic [35:0] hi);
    int          ones;
    logic [35:0] span;
    ones = 0;
    while (ones < 32 && word[ones]) ones++;
    lo = '0;
    hi = '0;
    case (mode)
      MODE_TOR: begin
        lo = (idx == 0) ? 36'd0 : {2'b00, prev, 2'b00};
        hi = {2'b00, word, 2'b00};
      end
      MODE_NA4: begin
        lo = {2'b00, word, 2'b00};
        hi = lo + 36'd4;
      end
      MODE_NAPOT: begin
        span = 36'd1 << (ones + 3);
        lo = {2'b00, word, 2'b00} & ~(span - 36'd1);
        hi = lo + span;
      end
      default: ;
    endcase
  endfunction

  function automatic res_t check_regions(logic [33:0] addr, logic [1:0] kind);
    res_t        r;
    logic [35:0] lo;
    logic [35:0] hi;
    logic [1:0]  mode;
    r = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      mode = prot_setting[i][4:3];
      region_bounds(i, mode, prot_word[i], prot_word[(i == 0) ? 0 : i - 1], lo, hi);
      if (mode != MODE_OFF && lo <= {2'b00, addr} && {2'b00, addr} < hi) begin
        r.region_hit = 1'b1;
        r.hit_index  = 6'(i);
        r.granted    = (kind <= KIND_EXEC) ? prot_setting[i][kind] : 1'b0;
        return r;
      end
    end
    return r;
  endfunction

  function automatic void apply_item(req_t req);
    case (req.action)
      ACT_CHECK: pending_verdicts.push_back(check_regions(req.phys_address, req.access_kind));
      ACT_SET:   prot_setting[req.entry_index] = req.write_data[7:0];
      ACT_WORD:  prot_word[req.entry_index] = req.write_data;
      default: ;
    endcase
  endfunction

  function automatic bit may_send(access_item_t it);
    if (it.drain && pending_verdicts.size() != 0) return 1'b0;
    return $urandom_range(99) >= it.gap_pct;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) apply_item(request);
      if (!start || !busy) begin
        if (access_items.size() != 0 && may_send(access_items[0])) begin
          request <= access_items[0].req;
          start   <= 1'b1;
          void'(access_items.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic field_check(string name, logic [5:0] want, logic [5:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result with none expected, actual %p", $time, result);
        errors++;
      end else begin
        verdict = pending_verdicts.pop_front();
        field_check("granted", 6'(verdict.granted), 6'(result.granted));
        field_check("region_hit", 6'(verdict.region_hit), 6'(result.region_hit));
        field_check("hit_index", verdict.hit_index, result.hit_index);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic add_item(logic [1:0] act, logic [5:0] idx, logic [31:0] data,
                          logic [33:0] addr, logic [1:0] kind);
    access_item_t it;
    it.req.action       = act;
    it.req.entry_index  = idx;
    it.req.write_data   = data;
    it.req.phys_address = addr;
    it.req.access_kind  = kind;
    it.gap_pct          = cur_gap;
    it.drain            = drain_next;
    drain_next          = 1'b0;
    access_items.push_back(it);
    if (act == ACT_SET) plan_mode[idx] = data[4:3];
    if (act == ACT_WORD) plan_word[idx] = data;
    if (act != ACT_UNUSED) n_items++;
  endtask

  task automatic set_entry(logic [5:0] idx, logic [7:0] setting);
    add_item(ACT_SET, idx, {24'($urandom), setting}, 34'({$urandom, $urandom}), 2'($urandom));
  endtask

  task automatic word_entry(logic [5:0] idx, logic [31:0] word);
    add_item(ACT_WORD, idx, word, 34'({$urandom, $urandom}), 2'($urandom));
  endtask

  task automatic check(logic [33:0] addr, logic [1:0] kind);
    add_item(ACT_CHECK, 6'($urandom), $urandom, addr, kind);
  endtask

  function automatic logic [33:0] aim_addr(int idx);
    logic [35:0] lo;
    logic [35:0] hi;
    logic [35:0] a;
    region_bounds(idx, plan_mode[idx], plan_word[idx], plan_word[(idx == 0) ? 0 : idx - 1],
                  lo, hi);
    case ($urandom_range(5))
      0: a = lo;
      1: a = hi - 36'd1;
      2: a = hi;
      3: a = lo - 36'd1;
      4: a = (hi > lo) ? lo + 36'(64'({$urandom, $urandom}) % 64'(hi - lo)) : lo;
      default: a = 36'({$urandom, $urandom});
    endcase
    return a[33:0];
  endfunction

  function automatic logic [31:0] pick_word(logic [1:0] mode, int idx);
    logic [31:0] w;
    int          t;
    int          r;
    w = $urandom;
    if (mode == MODE_NAPOT) begin
      r = $urandom_range(19);
      t = (r == 0) ? 32 : (r < 4) ? $urandom_range(31) : $urandom_range(10);
      if (t == 32) w = '1;
      else w = (w & ~((32'd2 << t) - 32'd1)) | ((32'd1 << t) - 32'd1);
    end else if (mode == MODE_TOR && idx > 0 && $urandom_range(3) != 0) begin
      w = plan_word[idx - 1] + 32'($urandom_range(256));
    end
    return w;
  endfunction

  initial begin : stimulus
    int         touched[$];
    int         idx;
    logic [1:0] mode;
    logic [1:0] kind;
    logic [33:0] addr;

    for (int i = 0; i < NUM_ENTRIES; i++) begin
      prot_setting[i] = '0;
      prot_word[i]    = '0;
      plan_mode[i]    = MODE_OFF;
      plan_word[i]    = '0;
    end

    // directed part
    drain_next = 1'b1;
    check(34'h0, KIND_READ);
    word_entry(6'd0, 32'h100);
    set_entry(6'd0, {3'b000, MODE_TOR, PERM_R});
    check(34'h3FF, KIND_READ);
    check(34'h400, KIND_READ);
    check(34'h0, KIND_WRITE);
    check(34'h10, KIND_UNUSED);
    word_entry(6'd1, 32'h200);
    set_entry(6'd1, {3'b111, MODE_NA4, PERM_X});
    check(34'h800, KIND_EXEC);
    check(34'h803, KIND_READ);
    check(34'h804, KIND_EXEC);
    word_entry(6'd2, 32'hFFFF_FFFF);
    set_entry(6'd2, {3'b000, MODE_NAPOT, PERM_R | PERM_W});
    check(34'h3_FFFF_FFFF, KIND_WRITE);
    check(34'h0, KIND_EXEC);
    set_entry(6'd2, {3'b000, MODE_OFF, 3'b000});
    word_entry(6'd63, 32'h1000);
    set_entry(6'd63, {3'b000, MODE_NAPOT, PERM_R | PERM_W | PERM_X});
    check(34'h4007, KIND_EXEC);
    check(34'h4008, KIND_EXEC);
    check(34'h3FFF, KIND_READ);
    // TOR with a lower bound above its top: empty region
    word_entry(6'd3, 32'h300);
    set_entry(6'd3, {3'b000, MODE_TOR, PERM_R | PERM_W | PERM_X});
    check(34'h900, KIND_READ);
    add_item(ACT_UNUSED, '1, '1, '1, '1);

    // random scenarios
    for (int sc = 0; n_items < ITEM_TARGET; sc++) begin
      cur_gap    = (sc % 4 == 1) ? 60 : (sc % 4 == 3) ? 24 : 0;
      drain_next = (sc % 12 == 5);
      touched.delete();
      repeat ($urandom_range(5)) set_entry(6'($urandom), {3'($urandom), MODE_OFF, 3'($urandom)});
      repeat ($urandom_range(6, 1)) begin
        idx  = $urandom_range(NUM_ENTRIES - 1);
        mode = 2'($urandom);
        word_entry(6'(idx), pick_word(mode, idx));
        set_entry(6'(idx), {3'($urandom), mode, 3'($urandom)});
        touched.push_back(idx);
      end
      repeat ($urandom_range(30, 8)) begin
        if ($urandom_range(15) == 0)
          add_item(ACT_UNUSED, 6'($urandom), $urandom, 34'({$urandom, $urandom}), 2'($urandom));
        kind = ($urandom_range(9) == 0) ? KIND_UNUSED : 2'($urandom_range(2));
        case ($urandom_range(9))
          0, 1:    addr = 34'({$urandom, $urandom});
          2:       addr = aim_addr($urandom_range(NUM_ENTRIES - 1));
          default: addr = aim_addr(touched[$urandom_range(touched.size() - 1)]);
        endcase
        check(addr, kind);
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (access_items.size() != 0 || start || pending_verdicts.size() != 0);
    repeat (SETTLE) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_verdicts.size());
      errors++;
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
